/* src/block_bitmap_allocator_core_defines.svh */
// Assertion macros for the block bitmap allocator.
// Included by the top level; depends on nothing else.
`ifndef BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBAL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bbal assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bbal assertion failed");

`endif

/* src/bbal_pkg.sv */
// Shared types and constants of the block bitmap allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bbal_pkg;

    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int WORD_BITS = 32;
    localparam int POS_W     = 5;
    localparam int IDX_LIMIT = 4096;

    localparam logic [CNT_W-1:0] CNT_MAX        = 13'h1FFF;
    localparam logic [CNT_W-1:0] BC_RESET       = 13'd4096;
    localparam logic [IDX_W-1:0] FDB_RESET      = 12'd1;
    // Block count minus first data block at the reset register values.
    localparam logic [CNT_W-1:0] FREE_CNT_RESET = 13'd4095;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2,
        OP_TEST  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_RANGE    = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        CFG_BLOCK_COUNT      = 1'b0,
        CFG_FIRST_DATA_BLOCK = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } ffz_t;

endpackage

`default_nettype wire

/* src/bbal_map_mem.sv */
// Usage map storage: one word of block bits per row, one write and one read port.
// Depends on bbal_pkg for the word width.
`default_nettype none

module bbal_map_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic                           aclk,
    input  wire logic                           we,
    input  wire logic [AW-1:0]                  waddr,
    input  wire logic [bbal_pkg::WORD_BITS-1:0] wdata,
    input  wire logic                           re,
    input  wire logic [AW-1:0]                  raddr,
    output logic      [bbal_pkg::WORD_BITS-1:0] rdata
);

    logic [bbal_pkg::WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/bbal_ffz.sv */
// Find-first-zero unit: lowest clear bit of one map word after range masking.
// Depends on bbal_pkg for the word width and the result struct.
`default_nettype none

module bbal_ffz (
    input  wire logic [bbal_pkg::WORD_BITS-1:0] word,
    input  wire logic                           low_en,
    input  wire logic [bbal_pkg::POS_W-1:0]     low_pos,
    input  wire logic                           high_en,
    input  wire logic [bbal_pkg::POS_W-1:0]     high_pos,
    output bbal_pkg::ffz_t                      result
);

    logic [bbal_pkg::WORD_BITS-1:0] low_mask;
    logic [bbal_pkg::WORD_BITS-1:0] high_mask;
    logic [bbal_pkg::WORD_BITS-1:0] free_bits;
    logic [bbal_pkg::WORD_BITS-1:0] lowest;

    // Bits below the first data block and above the last valid block count as used.
    assign low_mask  = low_en  ? ((32'd1 << low_pos) - 32'd1) : '0;
    assign high_mask = high_en ? (32'hFFFF_FFFE << high_pos) : '0;
    assign free_bits = ~(word | low_mask | high_mask);
    assign lowest    = free_bits & (~free_bits + 32'd1);

    always_comb begin
        result.found = |free_bits;
        result.pos   = '0;
        for (int i = 0; i < bbal_pkg::WORD_BITS; i++) begin
            if (lowest[i]) begin
                result.pos = result.pos | bbal_pkg::POS_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

/* src/block_bitmap_allocator_core.sv */
// Block bitmap allocator: first-fit allocation over a one-bit-per-block usage map.
// Allocate reads the 32-bit map words in turn, from the word of the first data block up
// to the last in range (up to 128 by default), and stops at the first clear bit; free,
// mark and test read one word, refused items none; a new item is taken only once the last
// result is in the output register. After reset a clearing pass writes every map word, one
// a cycle (128 at the default size); no item is accepted until it ends. Control registers take reset values.
`default_nettype none
`include "block_bitmap_allocator_core_defines.svh"

module block_bitmap_allocator_core #(
    parameter int NUM_BLOCKS = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [1:0] op, [13:2] block_index, [15:14] zero
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [1:0] status, [13:2] granted_block,
                                        // [14] bit_value, [27:15] free_count, [31:28] zero
    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index, // 0 block_count, 1 first_data_block
    input  wire logic [12:0] cfg_data
);

    // Only block indexes below 4096 can ever be addressed, so the map never
    // needs more than that many bits.
    localparam int MAP_BLOCKS = (NUM_BLOCKS < bbal_pkg::IDX_LIMIT) ?
                                NUM_BLOCKS : bbal_pkg::IDX_LIMIT;
    localparam int WORDS = (MAP_BLOCKS + bbal_pkg::WORD_BITS - 1) / bbal_pkg::WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [AW-1:0]              LAST_ROW = AW'(WORDS - 1);
    localparam logic [bbal_pkg::CNT_W-1:0] MAP_LIM  = bbal_pkg::CNT_W'(MAP_BLOCKS);

    // Configuration registers.
    logic [bbal_pkg::CNT_W-1:0] bc_reg;
    logic [bbal_pkg::IDX_W-1:0] fdb_reg;

    // Sequencer state and the item in progress.
    bbal_pkg::state_t           state_reg, state_next;
    logic [AW-1:0]              clr_reg, clr_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic                       first_reg, first_next;
    bbal_pkg::op_t              op_reg, op_next;
    logic [bbal_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [bbal_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // Result of the item in progress, then the output register.
    bbal_pkg::status_t          res_status_reg, res_status_next;
    logic [bbal_pkg::IDX_W-1:0] res_granted_reg, res_granted_next;
    logic                       res_bit_reg, res_bit_next;
    logic                       m_valid_reg, m_valid_next;
    bbal_pkg::status_t          m_status_reg;
    logic [bbal_pkg::IDX_W-1:0] m_granted_reg;
    logic                       m_bit_reg;
    logic [bbal_pkg::CNT_W-1:0] m_count_reg;

    // Map port.
    logic                           mem_we, mem_re;
    logic [AW-1:0]                  mem_waddr, mem_raddr;
    logic [bbal_pkg::WORD_BITS-1:0] mem_wdata, mem_rdata;

    // Decode of the incoming item and the range limit.
    bbal_pkg::op_t              in_op;
    logic [bbal_pkg::IDX_W-1:0] in_idx;
    logic [bbal_pkg::CNT_W-1:0] lim;
    logic [bbal_pkg::CNT_W-1:0] lim_m1;
    logic [AW-1:0]              last_word;
    logic                       in_range;
    logic                       alloc_ok;
    logic                       accept;
    logic                       idle_read;
    logic                       eval_done;
    logic                       out_free;
    logic                       out_load;
    logic [bbal_pkg::WORD_BITS-1:0] bit_onehot;
    logic [AW-1:0]              ptr_inc;

    bbal_pkg::ffz_t ffz;
    logic           ffz_high;

    assign in_op     = bbal_pkg::op_t'(s_tdata[1:0]);
    assign in_idx    = s_tdata[13:2];
    assign lim       = (bc_reg > MAP_LIM) ? MAP_LIM : bc_reg;
    assign lim_m1    = lim - 13'd1;
    assign last_word = lim_m1[AW+4:5];
    assign in_range  = {1'b0, in_idx} < lim;
    assign alloc_ok  = {1'b0, fdb_reg} < lim;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign out_load  = (state_reg == bbal_pkg::S_DONE) && out_free;
    assign ptr_inc   = ptr_reg + AW'(1);
    assign bit_onehot = 32'd1 << idx_reg[4:0];
    assign ffz_high  = (ptr_reg == last_word);

    // An accepted item reads the map unless it is refused at once.
    always_comb begin
        if (in_op == bbal_pkg::OP_ALLOC) begin
            idle_read = alloc_ok;
        end else if (in_op == bbal_pkg::OP_FREE) begin
            idle_read = in_range && (in_idx != '0);
        end else begin
            idle_read = in_range;
        end
    end

    // Allocation ends on a clear bit or on the last word in range; the rest
    // finish after a single read.
    assign eval_done = (op_reg != bbal_pkg::OP_ALLOC) || ffz.found || ffz_high;

    bbal_map_mem #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_map (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The search unit only masks the first word read below the first data
    // block and the last word in range above the limit.
    bbal_ffz u_ffz (
        .word     (mem_rdata),
        .low_en   (first_reg),
        .low_pos  (fdb_reg[4:0]),
        .high_en  (ffz_high),
        .high_pos (lim_m1[4:0]),
        .result   (ffz)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bbal_pkg::S_CLEAR: begin
                if (clr_reg == LAST_ROW) begin
                    state_next = bbal_pkg::S_IDLE;
                end
            end
            bbal_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = idle_read ? bbal_pkg::S_EVAL : bbal_pkg::S_DONE;
                end
            end
            bbal_pkg::S_EVAL: begin
                if (eval_done) begin
                    state_next = bbal_pkg::S_DONE;
                end
            end
            bbal_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = bbal_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Datapath controls and next values.
    always_comb begin
        s_tready         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg;
        mem_wdata        = mem_rdata;
        mem_re           = 1'b0;
        mem_raddr        = ptr_reg;
        clr_next         = clr_reg;
        ptr_next         = ptr_reg;
        first_next       = first_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        res_bit_next     = res_bit_reg;

        unique case (state_reg)
            bbal_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            bbal_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    op_next          = in_op;
                    idx_next         = in_idx;
                    res_granted_next = '0;
                    res_bit_next     = 1'b0;
                    res_status_next  = bbal_pkg::STAT_OK;
                    first_next       = 1'b1;
                    if (in_op == bbal_pkg::OP_ALLOC) begin
                        mem_raddr = fdb_reg[AW+4:5];
                    end else begin
                        mem_raddr = in_idx[AW+4:5];
                    end
                    ptr_next = mem_raddr;
                    mem_re   = idle_read;
                    if (!idle_read) begin
                        res_status_next = (in_op == bbal_pkg::OP_ALLOC) ?
                                          bbal_pkg::STAT_NO_SPACE : bbal_pkg::STAT_RANGE;
                    end
                end
            end
            bbal_pkg::S_EVAL: begin
                unique case (op_reg)
                    bbal_pkg::OP_ALLOC: begin
                        if (ffz.found) begin
                            mem_we           = 1'b1;
                            mem_wdata        = mem_rdata | (32'd1 << ffz.pos);
                            res_granted_next = bbal_pkg::IDX_W'({ptr_reg, ffz.pos});
                            if (cnt_reg != '0) begin
                                cnt_next = cnt_reg - 13'd1;
                            end
                        end else if (ffz_high) begin
                            res_status_next = bbal_pkg::STAT_NO_SPACE;
                        end else begin
                            ptr_next   = ptr_inc;
                            first_next = 1'b0;
                            mem_re     = 1'b1;
                            mem_raddr  = ptr_inc;
                        end
                    end
                    bbal_pkg::OP_FREE: begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata & ~bit_onehot;
                        if (cnt_reg != bbal_pkg::CNT_MAX) begin
                            cnt_next = cnt_reg + 13'd1;
                        end
                    end
                    bbal_pkg::OP_MARK: begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata | bit_onehot;
                    end
                    bbal_pkg::OP_TEST: begin
                        res_bit_next = mem_rdata[idx_reg[4:0]];
                    end
                endcase
            end
            bbal_pkg::S_DONE: begin
            end
        endcase
    end

    // The output register holds a result until it is taken; a new item may be
    // accepted meanwhile.
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bbal_pkg::S_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= bbal_pkg::FREE_CNT_RESET;
            m_valid_reg <= 1'b0;
            bc_reg      <= bbal_pkg::BC_RESET;
            fdb_reg     <= bbal_pkg::FDB_RESET;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (bbal_pkg::cfg_reg_t'(cfg_index))
                    bbal_pkg::CFG_BLOCK_COUNT:      bc_reg  <= cfg_data;
                    bbal_pkg::CFG_FIRST_DATA_BLOCK: fdb_reg <= cfg_data[11:0];
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        ptr_reg         <= ptr_next;
        first_reg       <= first_next;
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        res_bit_reg     <= res_bit_next;
        if (out_load) begin
            m_status_reg  <= res_status_reg;
            m_granted_reg <= res_granted_reg;
            m_bit_reg     <= res_bit_reg;
            m_count_reg   <= cnt_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0000, m_count_reg, m_bit_reg, m_granted_reg, 2'(m_status_reg)};

    // An accepted item keeps the input side closed on the following cycle.
    `BBAL_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A granted block lies between the first data block and the limit.
    `BBAL_ASSERT_NOW(a_grant_range, aclk, aresetn, out_load && (op_reg == bbal_pkg::OP_ALLOC) && (res_status_reg == bbal_pkg::STAT_OK), (res_granted_reg >= fdb_reg) && ({1'b0, res_granted_reg} < lim))
    // The free counter moves only while an item is at work.
    `BBAL_ASSERT_NEXT(a_cnt_idle, aclk, aresetn, (state_reg == bbal_pkg::S_IDLE) && !accept, $stable(cnt_reg))
    // The map is never written while the block waits for an item.
    `BBAL_ASSERT_NOW(a_no_idle_write, aclk, aresetn, (state_reg == bbal_pkg::S_IDLE) || (state_reg == bbal_pkg::S_DONE), !mem_we)

endmodule

`default_nettype wire
